FILE: rtl/core/isl_pkg.sv
// ----------------------------------------------------------------------------
// isl_pkg
// shared field widths and command codes of the indexed list store
// ----------------------------------------------------------------------------
`default_nettype none

package isl_pkg;

  localparam int CMD_W       = 2;
  localparam int POS_W       = 5;
  localparam int FIELD_W     = 32;
  localparam int CNT_FIELD_W = 5;

  localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/core/isl_mem.sv
// ----------------------------------------------------------------------------
// isl_mem
// entry memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module isl_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/isl_ctrl.sv
// ----------------------------------------------------------------------------
// isl_ctrl
// command sequencer: range checks, entry shifting through the memory,
// count register and result register
// ----------------------------------------------------------------------------
`default_nettype none

module isl_ctrl #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 4,
  parameter int CW         = 5
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [isl_pkg::CMD_W-1:0]       command,
  input  wire logic [isl_pkg::POS_W-1:0]       position,
  input  wire logic [isl_pkg::FIELD_W-1:0]     data_in,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [isl_pkg::FIELD_W-1:0]     data_out,
  output logic                                 error,
  output logic      [isl_pkg::CNT_FIELD_W-1:0] count,
  output logic                                 mem_we,
  output logic      [AW-1:0]                   mem_waddr,
  output logic      [DATA_WIDTH-1:0]           mem_wdata,
  output logic      [AW-1:0]                   mem_raddr,
  input  wire logic [DATA_WIDTH-1:0]           mem_rdata
);

  import isl_pkg::*;

  localparam int PW = (CW > POS_W) ? CW : POS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_GRAB = 2'd1;
  localparam logic [1:0] S_MOVE = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]            state;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         cnt_next;
  logic [CW-1:0]         moves_left;
  logic                  pend;
  logic                  up;
  logic [AW-1:0]         src;
  logic [AW-1:0]         dst;
  logic [CMD_W-1:0]      cmd_r;
  logic [AW-1:0]         pos_r;
  logic [DATA_WIDTH-1:0] word_r;
  logic [FIELD_W-1:0]    res_data;
  logic                  res_err;

  logic                  acc;
  logic                  out_load;
  logic [PW-1:0]         pos_ext;
  logic [PW-1:0]         cnt_ext;
  logic                  in_range;
  logic                  ins_ok;
  logic [63:0]           word_wide;
  logic [DATA_WIDTH-1:0] word_in;
  logic [63:0]           rd_wide;
  logic                  move_done;

  assign in_stall  = (state != S_IDLE);
  assign acc       = in_valid && !in_stall;
  assign out_load  = (state == S_RESP) && (!out_valid || !out_stall);
  assign pos_ext   = PW'(position);
  assign cnt_ext   = PW'(cnt);
  assign in_range  = pos_ext < cnt_ext;
  assign ins_ok    = (pos_ext <= cnt_ext) && (cnt != CW'(CAPACITY));
  assign word_wide = {32'b0, data_in};
  assign word_in   = word_wide[DATA_WIDTH-1:0];
  assign rd_wide   = 64'(mem_rdata);
  assign move_done = (state == S_MOVE) && (moves_left == '0) && !pend;

  always_comb begin
    cnt_next = cnt;
    if (!res_err) begin
      if (cmd_r == CMD_INSERT) begin
        cnt_next = cnt + CW'(1);
      end else if (cmd_r == CMD_REMOVE) begin
        cnt_next = cnt - CW'(1);
      end
    end
  end

  // memory access: direct set, shift moves, final insert write
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = dst;
    mem_wdata = mem_rdata;
    mem_raddr = (state == S_IDLE) ? pos_ext[AW-1:0] : src;
    if (acc && (command == CMD_SET) && in_range) begin
      mem_we    = 1'b1;
      mem_waddr = pos_ext[AW-1:0];
      mem_wdata = word_in;
    end else if ((state == S_MOVE) && pend) begin
      mem_we    = 1'b1;
      mem_waddr = dst;
      mem_wdata = mem_rdata;
    end else if (move_done && (cmd_r == CMD_INSERT)) begin
      mem_we    = 1'b1;
      mem_waddr = pos_r;
      mem_wdata = word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            cmd_r    <= command;
            pos_r    <= pos_ext[AW-1:0];
            word_r   <= word_in;
            res_data <= '0;
            pend     <= 1'b0;
            unique case (command)
              CMD_GET: begin
                res_err <= !in_range;
                state   <= in_range ? S_GRAB : S_RESP;
              end
              CMD_SET: begin
                res_err <= !in_range;
                state   <= S_RESP;
              end
              CMD_INSERT: begin
                res_err    <= !ins_ok;
                moves_left <= CW'(cnt_ext - pos_ext);
                src        <= AW'(cnt_ext - PW'(1));
                dst        <= cnt_ext[AW-1:0];
                up         <= 1'b1;
                state      <= ins_ok ? S_MOVE : S_RESP;
              end
              CMD_REMOVE: begin
                res_err    <= !in_range;
                moves_left <= CW'(cnt_ext - pos_ext - PW'(1));
                src        <= AW'(pos_ext + PW'(1));
                dst        <= pos_ext[AW-1:0];
                up         <= 1'b0;
                state      <= in_range ? S_GRAB : S_RESP;
              end
            endcase
          end
        end
        S_GRAB: begin
          res_data <= rd_wide[FIELD_W-1:0];
          state    <= (cmd_r == CMD_GET) ? S_RESP : S_MOVE;
        end
        S_MOVE: begin
          if (moves_left != '0) begin
            src        <= up ? src - AW'(1) : src + AW'(1);
            moves_left <= moves_left - CW'(1);
            pend       <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            dst <= up ? dst - AW'(1) : dst + AW'(1);
          end
          if (move_done) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_load) begin
            cnt       <= cnt_next;
            data_out  <= res_data;
            error     <= res_err;
            count     <= CNT_FIELD_W'(cnt_next);
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_move_addr: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state == S_MOVE)) |-> (PW'(mem_waddr) <= cnt_ext))
    else $error("shift write beyond list end");

  a_err_keeps_cnt: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_err) |=> (cnt == $past(cnt)))
    else $error("error result changed count");

  a_pend_in_move: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_MOVE))
    else $error("pending shift write outside move phase");

endmodule

`default_nettype wire

FILE: rtl/core/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store
// ordered list of data words addressed by position, with get, set,
// insert and remove commands
// ----------------------------------------------------------------------------
// input channel: command, position and data_in move on a transfer
// (in_valid high, in_stall low). output channel: data_out, error and count,
// one result per command, moved on a transfer (out_valid high, out_stall low).
// one command is worked at a time; in_stall is high while it runs.
// set and error cases go straight to the result; get first reads the entry;
// insert shifts the entries from the position up and then writes the word;
// remove reads the entry, then shifts the entries above it down. each shifted
// entry (up to CAPACITY-1) is a read-and-write-back pass through the single
// entry memory. a finished result sits in the output register; a new command
// is accepted meanwhile, and its result waits while out_stall is high.
// reset clears the count and the output valid; entry contents are unknown
// until written, and no command reads an entry at or beyond the count.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_store #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [isl_pkg::CMD_W-1:0]       command,
  input  wire logic [isl_pkg::POS_W-1:0]       position,
  input  wire logic [isl_pkg::FIELD_W-1:0]     data_in,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [isl_pkg::FIELD_W-1:0]     data_out,
  output logic                                 error,
  output logic      [isl_pkg::CNT_FIELD_W-1:0] count
);

  import isl_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  isl_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .position  (position),
    .data_in   (data_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_out  (data_out),
    .error     (error),
    .count     (count),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  isl_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
